@@ rtl/lcdnx_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdnx_pkg
// Shared types, codes and constants for the LCD nibble expander sequencer.
// ----------------------------------------------------------------------------
package lcdnx_pkg;

  localparam int LineLengthDefault = 16;
  localparam int QueueDepthDefault = 4;

  // input action codes
  localparam logic [1:0] ACT_CHAR = 2'd0;
  localparam logic [1:0] ACT_CMD  = 2'd1;
  localparam logic [1:0] ACT_INIT = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // expander port bits
  localparam logic [7:0] BIT_RS = 8'h01;
  localparam logic [7:0] BIT_EN = 8'h04;
  localparam logic [7:0] BIT_BL = 8'h08;

  localparam logic [7:0] CMD_LINE2 = 8'hC0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;

  localparam logic [3:0] INIT_LAST_STEP = 4'd11;
  localparam logic [3:0] BYTE_HI_STEP   = 4'd2;
  localparam logic [3:0] BYTE_LO_STEP   = 4'd3;
  localparam logic [3:0] WRAP_LO_STEP   = 4'd1;
  localparam logic [3:0] FIRST_STEP     = 4'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic       wrap;
    logic       emit;
    logic [7:0] value;
  } job_t;

  // nibbles of the init run: reset nibbles, then 0x28, 0x0C, 0x01, 0x06
  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] nib;
    unique case (step)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd6:             nib = 4'h0;
      4'd7:             nib = 4'hC;
      4'd8:             nib = 4'h0;
      4'd9:             nib = 4'h1;
      4'd10:            nib = 4'h0;
      4'd11:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

@@ rtl/lcdnx_front.sv @@
// ----------------------------------------------------------------------------
// lcdnx_front
// Accepts requests, tracks the column and turns each request other than ACT_NONE into a job.
// ----------------------------------------------------------------------------
module lcdnx_front #(
  parameter int LINE_LENGTH = lcdnx_pkg::LineLengthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // byte_value
  input  logic [2:0]        s_axis_tuser,  // action[1:0], first_of_string[2]
  input  logic              q_full,
  output logic              push,
  output lcdnx_pkg::job_t   push_job
);

  localparam int ColW = $clog2(LINE_LENGTH + 2);
  localparam logic [ColW-1:0] ColWrap = ColW'(LINE_LENGTH);
  localparam logic [ColW-1:0] ColSat  = ColW'(LINE_LENGTH + 1);

  logic [ColW-1:0] column, column_next, col_base;
  logic            wrap_done, wrap_done_next, wd_base;
  logic            accept, is_char, wrap;
  logic [1:0]      action;
  logic [7:0]      val, ch;

  assign s_axis_tready = !q_full;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign action  = s_axis_tuser[1:0];
  assign val     = s_axis_tdata;
  assign is_char = (action == lcdnx_pkg::ACT_CHAR);

  always_comb begin
    col_base = s_axis_tuser[2] ? '0 : column;
    wd_base  = s_axis_tuser[2] ? 1'b0 : wrap_done;
    wrap     = (col_base == ColWrap) && !wd_base;
    ch = (val >= lcdnx_pkg::CHAR_FIRST && val <= lcdnx_pkg::CHAR_LAST) ?
         val : lcdnx_pkg::CHAR_SPACE;
    column_next    = column;
    wrap_done_next = wrap_done;
    if (accept && is_char) begin
      column_next    = (col_base < ColSat) ? col_base + 1'b1 : col_base;
      wrap_done_next = wd_base || wrap;
    end
  end

  always_comb begin
    push_job.kind  = action;
    push_job.wrap  = is_char && wrap;
    push_job.emit  = !(is_char && wrap && val == lcdnx_pkg::CHAR_SPACE);
    push_job.value = is_char ? ch : val;
    push = accept && (action != lcdnx_pkg::ACT_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      wrap_done <= 1'b0;
    end else begin
      column    <= column_next;
      wrap_done <= wrap_done_next;
    end
  end

endmodule

@@ rtl/lcdnx_queue.sv @@
// ----------------------------------------------------------------------------
// lcdnx_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lcdnx_queue #(
  parameter int DEPTH = lcdnx_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdnx_pkg::job_t push_job,
  input  logic            pop,
  output lcdnx_pkg::job_t head,
  output logic            empty,
  output logic            full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  lcdnx_pkg::job_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CntFull);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lcdnx_back.sv @@
// ----------------------------------------------------------------------------
// lcdnx_back
// Steps through the nibbles of each job and drives the expander bytes.
// ----------------------------------------------------------------------------
module lcdnx_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_data,
  input  lcdnx_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // expander_byte
  output logic            m_axis_tlast   // last
);

  logic       backlight_on;
  logic       active, phase;
  logic [3:0] step;
  logic [3:0] cur_step, start_step, end_step;
  logic [3:0] nib;
  logic       rs, load, is_end;
  logic [7:0] byte_next;

  always_comb begin
    unique case (head.kind)
      lcdnx_pkg::ACT_CHAR: begin
        start_step = head.wrap ? lcdnx_pkg::FIRST_STEP : lcdnx_pkg::BYTE_HI_STEP;
        end_step   = head.emit ? lcdnx_pkg::BYTE_LO_STEP : lcdnx_pkg::WRAP_LO_STEP;
      end
      lcdnx_pkg::ACT_INIT: begin
        start_step = lcdnx_pkg::FIRST_STEP;
        end_step   = lcdnx_pkg::INIT_LAST_STEP;
      end
      default: begin
        start_step = lcdnx_pkg::BYTE_HI_STEP;
        end_step   = lcdnx_pkg::BYTE_LO_STEP;
      end
    endcase
    cur_step = active ? step : start_step;
    if (head.kind == lcdnx_pkg::ACT_INIT) begin
      nib = lcdnx_pkg::init_nibble(cur_step);
    end else begin
      unique case (cur_step[1:0])
        2'd0:    nib = lcdnx_pkg::CMD_LINE2[7:4];
        2'd1:    nib = lcdnx_pkg::CMD_LINE2[3:0];
        2'd2:    nib = head.value[7:4];
        default: nib = head.value[3:0];
      endcase
    end
    rs = (head.kind == lcdnx_pkg::ACT_CHAR) && cur_step[1];
    byte_next = {nib, 4'h0}
              | (backlight_on ? lcdnx_pkg::BIT_BL : 8'h00)
              | (phase ? 8'h00 : lcdnx_pkg::BIT_EN)
              | (rs ? lcdnx_pkg::BIT_RS : 8'h00);
    is_end = phase && (cur_step == end_step);
    load   = !empty && (!m_axis_tvalid || m_axis_tready);
    pop    = load && is_end;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= byte_next;
      m_axis_tlast <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on  <= 1'b1;
      m_axis_tvalid <= 1'b0;
      active        <= 1'b0;
      phase         <= 1'b0;
      step          <= '0;
    end else begin
      if (cfg_we) begin
        backlight_on <= cfg_data;
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (load) begin
        if (!phase) begin
          phase  <= 1'b1;
          step   <= cur_step;
          active <= 1'b1;
        end else if (is_end) begin
          phase  <= 1'b0;
          active <= 1'b0;
        end else begin
          phase <= 1'b0;
          step  <= cur_step + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/lcd_nibble_expander_sequencer.sv @@
// ----------------------------------------------------------------------------
// lcd_nibble_expander_sequencer
// Character LCD 4-bit sequencer for an 8-bit port expander.
// ----------------------------------------------------------------------------
// The first expander byte passes through the job queue and the registered
// output. One expander byte per cycle while a job is queued and the output
// is not stalled; 4 per character or command, 8 with the line-2 command (4
// when a space is swallowed there), 24 for init, set by the back nibble stepper.
// Requests are taken back to back while the job queue has room.
// Reset clears column, wrap flag, queue and output; backlight resets to on.
// ----------------------------------------------------------------------------
module lcd_nibble_expander_sequencer #(
  parameter int LINE_LENGTH = lcdnx_pkg::LineLengthDefault,
  parameter int QUEUE_DEPTH = lcdnx_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,       // backlight_on
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // byte_value
  input  logic [2:0] s_axis_tuser,   // action[1:0], first_of_string[2]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // expander_byte
  output logic       m_axis_tlast    // last
);

  lcdnx_pkg::job_t push_job, head;
  logic            push, pop, empty, full;

  lcdnx_front #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (full),
    .push          (push),
    .push_job      (push_job)
  );

  lcdnx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  lcdnx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/lcdnx_checker.sv @@
// ----------------------------------------------------------------------------
// lcdnx_checker
// Port-level checks for the LCD nibble expander sequencer.
// ----------------------------------------------------------------------------
module lcdnx_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // no output straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // hold a stalled transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // a run always ends on an enable-low byte
  a_last_en_low: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tlast)
    else $error("run ends with enable high");

  // write bit stays low
  a_write_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[1])
    else $error("read bit set");

endmodule

bind lcd_nibble_expander_sequencer lcdnx_checker u_lcdnx_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
